### design/ibalu_pkg.sv
// shared types, op codes and constants for the integer alu
package ibalu_pkg;

  localparam int DATA_WIDTH_DEF = 64;
  localparam int CMD_W          = 4;
  localparam int OPND_W         = 64;
  localparam int IN_TDATA_W     = 136;
  localparam int OUT_TDATA_W    = 72;
  localparam int STATUS_W       = 2;

  typedef enum logic [CMD_W-1:0] {
    OP_ADD = 4'd0,  OP_MUL = 4'd1,  OP_SUB = 4'd2,  OP_DIV = 4'd3,
    OP_REM = 4'd4,  OP_AND = 4'd5,  OP_OR  = 4'd6,  OP_XOR = 4'd7,
    OP_SHL = 4'd8,  OP_SHR = 4'd9,  OP_GT  = 4'd10, OP_LT  = 4'd11,
    OP_LE  = 4'd12, OP_GE  = 4'd13, OP_EQ  = 4'd14, OP_NE  = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    K_SIMPLE = 2'd0,
    K_MUL    = 2'd1,
    K_DIV    = 2'd2,
    K_REM    = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_SHIFT    = 2'd2
  } status_t;

  typedef struct packed {
    logic    valid;
    kind_t   kind;
    logic    neg_res;
    logic    is_bool;
    status_t status;
  } ctrl_t;

endpackage

### design/ibalu_front.sv
// entry stage: decode, the simple ops and setup of the multiply/divide chain
module ibalu_front #(
  parameter int DATA_WIDTH = ibalu_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [ibalu_pkg::CMD_W-1:0]          command,
  input  logic [ibalu_pkg::OPND_W-1:0]         left_operand,
  input  logic [ibalu_pkg::OPND_W-1:0]         right_operand,
  output ibalu_pkg::ctrl_t                     ctrl,
  output logic [DATA_WIDTH-1:0]                x,
  output logic [DATA_WIDTH-1:0]                y,
  output logic [DATA_WIDTH-1:0]                p
);

  localparam int SW = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] a, b, ua, ub, simple;
  logic                  shift_bad, b_zero;
  logic [SW-1:0]         amt;
  ibalu_pkg::ctrl_t      ctrl_next;
  logic [DATA_WIDTH-1:0] x_next, y_next, p_next;
  ibalu_pkg::op_t        op;

  assign op        = ibalu_pkg::op_t'(command);
  assign a         = left_operand[DATA_WIDTH-1:0];
  assign b         = right_operand[DATA_WIDTH-1:0];
  assign ua        = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
  assign ub        = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
  assign b_zero    = (b == '0);
  assign shift_bad = b[DATA_WIDTH-1] || (b >= DATA_WIDTH'(DATA_WIDTH));
  assign amt       = b[SW-1:0];

  always_comb begin
    ctrl_next.valid   = in_valid;
    ctrl_next.kind    = ibalu_pkg::K_SIMPLE;
    ctrl_next.neg_res = 1'b0;
    ctrl_next.is_bool = 1'b0;
    ctrl_next.status  = ibalu_pkg::ST_OK;
    simple = '0;
    x_next = '0;
    y_next = '0;
    unique case (op)
      ibalu_pkg::OP_ADD: simple = a + b;
      ibalu_pkg::OP_SUB: simple = a - b;
      ibalu_pkg::OP_AND: simple = a & b;
      ibalu_pkg::OP_OR:  simple = a | b;
      ibalu_pkg::OP_XOR: simple = a ^ b;
      ibalu_pkg::OP_MUL: begin
        ctrl_next.kind = ibalu_pkg::K_MUL;
        x_next = a;
        y_next = b;
      end
      ibalu_pkg::OP_DIV, ibalu_pkg::OP_REM: begin
        if (b_zero) begin
          ctrl_next.status = ibalu_pkg::ST_DIV_ZERO;
        end else begin
          ctrl_next.kind    = (op == ibalu_pkg::OP_DIV) ? ibalu_pkg::K_DIV : ibalu_pkg::K_REM;
          ctrl_next.neg_res = (op == ibalu_pkg::OP_DIV) ? (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1])
                                                        : a[DATA_WIDTH-1];
          x_next = ua;
          y_next = ub;
        end
      end
      ibalu_pkg::OP_SHL, ibalu_pkg::OP_SHR: begin
        if (shift_bad) ctrl_next.status = ibalu_pkg::ST_SHIFT;
        else if (op == ibalu_pkg::OP_SHL) simple = a << amt;
        else simple = $signed(a) >>> amt;
      end
      ibalu_pkg::OP_GT: begin
        ctrl_next.is_bool = 1'b1;
        simple = DATA_WIDTH'($signed(a) > $signed(b));
      end
      ibalu_pkg::OP_LT: begin
        ctrl_next.is_bool = 1'b1;
        simple = DATA_WIDTH'($signed(a) < $signed(b));
      end
      ibalu_pkg::OP_LE: begin
        ctrl_next.is_bool = 1'b1;
        simple = DATA_WIDTH'($signed(a) <= $signed(b));
      end
      ibalu_pkg::OP_GE: begin
        ctrl_next.is_bool = 1'b1;
        simple = DATA_WIDTH'($signed(a) >= $signed(b));
      end
      ibalu_pkg::OP_EQ: begin
        ctrl_next.is_bool = 1'b1;
        simple = DATA_WIDTH'(a == b);
      end
      ibalu_pkg::OP_NE: begin
        ctrl_next.is_bool = 1'b1;
        simple = DATA_WIDTH'(a != b);
      end
      default: simple = '0;
    endcase
    // simple results ride the accumulator through the chain untouched
    p_next = simple;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl.kind    <= ctrl_next.kind;
      ctrl.neg_res <= ctrl_next.neg_res;
      ctrl.is_bool <= ctrl_next.is_bool;
      ctrl.status  <= ctrl_next.status;
      x <= x_next;
      y <= y_next;
      p <= p_next;
    end
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else if (en) begin
      ctrl.valid <= ctrl_next.valid;
    end
  end

endmodule

### design/ibalu_cell.sv
// one chain cell: one shift-add multiply step, one restoring divide step, or a pass-through for simple results
module ibalu_cell #(
  parameter int DATA_WIDTH = ibalu_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  ibalu_pkg::ctrl_t      ctrl_in,
  input  logic [DATA_WIDTH-1:0] x_in,
  input  logic [DATA_WIDTH-1:0] y_in,
  input  logic [DATA_WIDTH-1:0] p_in,
  output ibalu_pkg::ctrl_t      ctrl_out,
  output logic [DATA_WIDTH-1:0] x_out,
  output logic [DATA_WIDTH-1:0] y_out,
  output logic [DATA_WIDTH-1:0] p_out
);

  logic [DATA_WIDTH:0]   rr, diff;
  logic                  ge;
  logic [DATA_WIDTH-1:0] x_next, y_next, p_next;

  // divide: x holds dividend bits shifting out and quotient bits shifting in
  assign rr   = {p_in, x_in[DATA_WIDTH-1]};
  assign diff = rr - {1'b0, y_in};
  assign ge   = !diff[DATA_WIDTH];

  always_comb begin
    x_next = x_in;
    y_next = y_in;
    p_next = p_in;
    unique case (ctrl_in.kind)
      ibalu_pkg::K_MUL: begin
        p_next = y_in[0] ? (p_in + x_in) : p_in;
        x_next = x_in << 1;
        y_next = y_in >> 1;
      end
      ibalu_pkg::K_DIV, ibalu_pkg::K_REM: begin
        p_next = ge ? diff[DATA_WIDTH-1:0] : rr[DATA_WIDTH-1:0];
        x_next = {x_in[DATA_WIDTH-2:0], ge};
      end
      default: p_next = p_in;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_out.kind    <= ctrl_in.kind;
      ctrl_out.neg_res <= ctrl_in.neg_res;
      ctrl_out.is_bool <= ctrl_in.is_bool;
      ctrl_out.status  <= ctrl_in.status;
      x_out <= x_next;
      y_out <= y_next;
      p_out <= p_next;
    end
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else if (en) begin
      ctrl_out.valid <= ctrl_in.valid;
    end
  end

endmodule

### design/integer_binary_alu.sv
// top level: pipelined 64-bit integer alu built from a chain of step cells
//
//   channel   dir  payload
//   s_*       in   tdata: command[3:0], left_operand[67:4], right_operand[131:68]
//   m_*       out  tdata: result_value[63:0], status[65:64]; tuser: is_boolean
//
// stages: entry stage, one cell per operand bit, output register
// one item per cycle unless the output stalls; each cell does one multiply add or one quotient bit
// the whole pipe advances together and holds while m_tvalid is high and m_tready low
// rst is synchronous and empties the pipe; no other state exists
module integer_binary_alu #(
  parameter int DATA_WIDTH = ibalu_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ibalu_pkg::IN_TDATA_W-1:0]    s_tdata,   // command, left_operand, right_operand
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ibalu_pkg::OUT_TDATA_W-1:0]   m_tdata,   // result_value, status
  output logic                                m_tuser    // is_boolean
);

  ibalu_pkg::ctrl_t      ctrl [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] x    [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] y    [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] p    [DATA_WIDTH+1];
  logic                  en;
  logic [DATA_WIDTH-1:0] fin;
  logic [ibalu_pkg::OPND_W-1:0] result_value;
  logic [ibalu_pkg::STATUS_W-1:0] status;
  ibalu_pkg::ctrl_t      last;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  ibalu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid),
    .command(s_tdata[3:0]),
    .left_operand(s_tdata[67:4]),
    .right_operand(s_tdata[131:68]),
    .ctrl(ctrl[0]), .x(x[0]), .y(y[0]), .p(p[0])
  );

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    ibalu_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .ctrl_in(ctrl[i]), .x_in(x[i]), .y_in(y[i]), .p_in(p[i]),
      .ctrl_out(ctrl[i+1]), .x_out(x[i+1]), .y_out(y[i+1]), .p_out(p[i+1])
    );
  end

  assign last = ctrl[DATA_WIDTH];

  always_comb begin
    unique case (last.kind)
      ibalu_pkg::K_DIV: fin = last.neg_res ? (~x[DATA_WIDTH] + 1'b1) : x[DATA_WIDTH];
      ibalu_pkg::K_REM: fin = last.neg_res ? (~p[DATA_WIDTH] + 1'b1) : p[DATA_WIDTH];
      default:          fin = p[DATA_WIDTH];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_value <= ibalu_pkg::OPND_W'($signed(fin));
      status       <= last.status;
      m_tuser      <= last.is_bool;
    end
  end

  assign m_tdata = {{(ibalu_pkg::OUT_TDATA_W - ibalu_pkg::OPND_W - ibalu_pkg::STATUS_W){1'b0}},
                    status, result_value};

  // compare results are 0 or 1 and carry no error
  a_bool_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (result_value[ibalu_pkg::OPND_W-1:1] == '0) &&
                            (status == ibalu_pkg::ST_OK))
    else $error("boolean result out of range");

  // any error reports a zero result
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status != ibalu_pkg::ST_OK) |-> (result_value == '0))
    else $error("error status with nonzero result");

  // a held result keeps its contents while the pipe is frozen
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(result_value) && $stable(status))
    else $error("stalled result changed");

  // the chain only moves when the output can take an item
  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(ctrl[DATA_WIDTH].valid) && $stable(p[DATA_WIDTH]))
    else $error("chain advanced during stall");

endmodule

### sim/integer_binary_alu_tb.sv
// testbench for the pipelined 64-bit integer alu: random and corner operations vs a predictor
module integer_binary_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW        = ibalu_pkg::DATA_WIDTH_DEF;
  localparam int N_RANDOM  = 650;
  localparam int WD_LIMIT  = 20000;
  localparam int DRAIN_CYC = DW + 20;

  typedef struct packed {
    logic [63:0] value;
    logic        boolean;
    logic [1:0]  stat;
  } alu_result_t;

  function automatic logic [63:0] sx(logic [63:0] v);
    logic [63:0] m;
    m = (DW == 64) ? '1 : ((64'd1 << DW) - 1);
    v = v & m;
    return (v ^ (64'd1 << (DW - 1))) - (64'd1 << (DW - 1));
  endfunction

  function automatic alu_result_t alu_predict(ibalu_pkg::op_t op, logic [63:0] l,
                                              logic [63:0] r);
    alu_result_t res;
    logic signed [63:0] a, b;
    logic [63:0] ua, ub, q;
    a = sx(l);
    b = sx(r);
    res = '0;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    case (op)
      ibalu_pkg::OP_ADD: res.value = sx(a + b);
      ibalu_pkg::OP_MUL: res.value = sx(a * b);
      ibalu_pkg::OP_SUB: res.value = sx(a - b);
      ibalu_pkg::OP_DIV, ibalu_pkg::OP_REM: begin
        if (b == 0) res.stat = ibalu_pkg::ST_DIV_ZERO;
        else if (op == ibalu_pkg::OP_DIV) begin
          q = ua / ub;
          res.value = sx((a[63] != b[63]) ? -q : q);
        end else begin
          q = ua % ub;
          res.value = sx(a[63] ? -q : q);
        end
      end
      ibalu_pkg::OP_AND: res.value = a & b;
      ibalu_pkg::OP_OR:  res.value = a | b;
      ibalu_pkg::OP_XOR: res.value = a ^ b;
      ibalu_pkg::OP_SHL, ibalu_pkg::OP_SHR: begin
        if (b < 0 || b >= DW) res.stat = ibalu_pkg::ST_SHIFT;
        else if (op == ibalu_pkg::OP_SHL) res.value = sx(a << b[5:0]);
        else res.value = a >>> b[5:0];
      end
      ibalu_pkg::OP_GT: begin res.boolean = 1'b1; res.value = 64'(a > b);  end
      ibalu_pkg::OP_LT: begin res.boolean = 1'b1; res.value = 64'(a < b);  end
      ibalu_pkg::OP_LE: begin res.boolean = 1'b1; res.value = 64'(a <= b); end
      ibalu_pkg::OP_GE: begin res.boolean = 1'b1; res.value = 64'(a >= b); end
      ibalu_pkg::OP_EQ: begin res.boolean = 1'b1; res.value = 64'(a == b); end
      default: begin res.boolean = 1'b1; res.value = 64'(a != b); end
    endcase
    return res;
  endfunction

  int errors = 0;

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  class alu_scoreboard;
    alu_result_t pending[$];
    function void note_op(ibalu_pkg::op_t op, logic [63:0] l, logic [63:0] r);
      pending.push_back(alu_predict(op, l, r));
    endfunction
    task check_result(logic [63:0] value, logic boolean, logic [1:0] stat);
      alu_result_t exp_r;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", value));
        return;
      end
      exp_r = pending.pop_front();
      if (value !== exp_r.value)
        report($sformatf("value got %h want %h", value, exp_r.value));
      if (boolean !== exp_r.boolean)
        report($sformatf("is_boolean got %b want %b", boolean, exp_r.boolean));
      if (stat !== exp_r.stat)
        report($sformatf("status got %0d want %0d", stat, exp_r.stat));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [ibalu_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [ibalu_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic m_tuser;

  integer_binary_alu dut (.*);

  always #5 clk = ~clk;

  alu_scoreboard sb = new();
  bit quiet_phase = 0;   // no idling on either side
  bit hold_off = 0;      // long receiver stall
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst) idle_cycles <= 0;
    else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: sample on accept, then choose ready for next cycle
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata[63:0], m_tuser, m_tdata[65:64]);
    if (rst || hold_off) m_tready <= 0;
    else m_tready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 11);
  end

  task automatic send_op(ibalu_pkg::op_t op, logic [63:0] l, logic [63:0] r);
    if (!quiet_phase)
      while ($urandom_range(99) < 11) begin
        s_tvalid <= 0;
        @(posedge clk);
      end
    s_tvalid <= 1;
    s_tdata <= {4'b0, r, l, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_op(op, l, r);
  endtask

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = 64'(int'($urandom_range(9)) - 4);
      1: v = {1'b1, 63'b0} + 64'($urandom_range(3));
      2: v = {1'b0, {63{1'b1}}} - 64'($urandom_range(3));
      3: v = v >> $urandom_range(63);
      default: ;
    endcase
    return v;
  endfunction

  localparam logic [63:0] MINV = {1'b1, 63'b0};
  localparam logic [63:0] MAXV = {1'b0, {63{1'b1}}};

  initial begin
    ibalu_pkg::op_t op;
    logic [63:0] r;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // corner cases: extremes, zero divisor, min / -1, shifts out of range
    send_op(ibalu_pkg::OP_ADD, MAXV, 64'd1);
    send_op(ibalu_pkg::OP_MUL, MINV, '1);
    send_op(ibalu_pkg::OP_SUB, MINV, 64'd1);
    send_op(ibalu_pkg::OP_DIV, 64'd7, 64'd0);
    send_op(ibalu_pkg::OP_REM, MINV, 64'd0);
    send_op(ibalu_pkg::OP_DIV, MINV, '1);
    send_op(ibalu_pkg::OP_REM, MINV, '1);
    send_op(ibalu_pkg::OP_DIV, -64'sd7, 64'd2);
    send_op(ibalu_pkg::OP_REM, -64'sd7, 64'd2);
    send_op(ibalu_pkg::OP_AND, '1, MAXV);
    send_op(ibalu_pkg::OP_OR, MINV, 64'd5);
    send_op(ibalu_pkg::OP_XOR, '1, MINV);
    send_op(ibalu_pkg::OP_SHL, '1, 64'd63);
    send_op(ibalu_pkg::OP_SHR, MINV, 64'd63);
    send_op(ibalu_pkg::OP_SHL, 64'd1, 64'd64);
    send_op(ibalu_pkg::OP_SHR, MINV, '1);
    send_op(ibalu_pkg::OP_SHR, MAXV, 64'd0);
    send_op(ibalu_pkg::OP_GT, MAXV, MINV);
    send_op(ibalu_pkg::OP_LT, MAXV, MINV);
    send_op(ibalu_pkg::OP_LE, 64'd3, 64'd3);
    send_op(ibalu_pkg::OP_GE, MINV, MAXV);
    send_op(ibalu_pkg::OP_EQ, '1, '1);
    send_op(ibalu_pkg::OP_NE, '1, '1);
    for (int i = 0; i < N_RANDOM; i++) begin
      quiet_phase = (i >= 200 && i < 300);
      if (i == 400) begin
        hold_off = 1;
        fork
          begin
            repeat (150) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      op = ibalu_pkg::op_t'(4'($urandom_range(15)));
      r = rand_operand();
      if ((op == ibalu_pkg::OP_SHL || op == ibalu_pkg::OP_SHR) && $urandom_range(3) != 0)
        r = 64'($urandom_range(DW - 1));
      if ((op == ibalu_pkg::OP_DIV || op == ibalu_pkg::OP_REM) && $urandom_range(9) == 0)
        r = '0;
      send_op(op, rand_operand(), r);
    end
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
